FILE: rtl/tlbs_pkg.sv
package tlbs_pkg;

  localparam int TableDepth = 1024;
  localparam int DataWidth  = 32;
  localparam int AddrWidth  = $clog2(TableDepth);
  localparam int CntWidth   = $clog2(TableDepth + 1);

  localparam int EntryCountWidth = 11;
  localparam int FuncWidth       = 2;
  localparam int IndexWidth      = 10;
  localparam int PositionWidth   = 10;
  localparam int ApbAddrWidth    = 3;
  localparam int ApbDataWidth    = 32;

  localparam logic [FuncWidth-1:0] FuncWrite  = 2'd0;
  localparam logic [FuncWidth-1:0] FuncLinear = 2'd1;
  localparam logic [FuncWidth-1:0] FuncBinary = 2'd2;

  localparam logic RegEntryCount = 1'b0;

endpackage

FILE: rtl/table_linear_binary_search_unit.sv
// Table of signed 32-bit entries with linear and binary search. entry_count (APB, offset 0)
// sets how many entries from index 0 are searched; values above the depth are clamped. A write
// item (func 0) gives no result; func 3 is dropped. A linear search reads one entry per cycle
// through the single registered read port of the table memory. A binary search expects
// ascending order; each probe is a memory read, then one shared signed compare. The input
// is not ready while a search runs; a finished result sits in an output register, so a new
// item can be taken while it waits.
module table_linear_binary_search_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [tlbs_pkg::FuncWidth-1:0]         func_i,
  input  logic [tlbs_pkg::IndexWidth-1:0]        index_i,
  input  logic signed [tlbs_pkg::DataWidth-1:0]  value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   found_o,
  output logic [tlbs_pkg::PositionWidth-1:0]     position_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tlbs_pkg::ApbAddrWidth-1:0]      paddr,
  input  logic [tlbs_pkg::ApbDataWidth-1:0]      pwdata,
  output logic [tlbs_pkg::ApbDataWidth-1:0]      prdata,
  output logic                                   pready
);

  localparam int AddrW = tlbs_pkg::AddrWidth;
  localparam int CntW  = tlbs_pkg::CntWidth;
  localparam int EcW   = tlbs_pkg::EntryCountWidth;
  localparam int SatW  = (CntW > EcW) ? CntW : EcW;
  localparam int DW    = tlbs_pkg::DataWidth;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StBProbe = 3'd2;
  localparam logic [2:0] StBCmp   = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [EcW-1:0]   entry_count_q;
  logic [CntW-1:0]  scan_q, lo_q, end_q;
  logic [AddrW-1:0] mid_q, pend_idx_q, res_pos_q;
  logic             pend_vld_q, res_found_q;
  logic [DW-1:0]    key_q, rdata_q;
  logic [DW-1:0]    mem_q [tlbs_pkg::TableDepth];
  logic             out_valid_q, found_q;
  logic [tlbs_pkg::PositionWidth-1:0] position_q;

  logic [SatW-1:0]  ec_ext;
  logic [CntW-1:0]  count;
  logic [CntW:0]    mid_sum;
  logic [AddrW-1:0] mid, rd_addr;
  logic             accept, issue, probe_ok, mem_re, mem_we, out_load, cfg_we;
  logic             key_eq, key_lt;

  assign ec_ext   = SatW'(entry_count_q);
  assign count    = (ec_ext > SatW'(tlbs_pkg::TableDepth)) ? CntW'(tlbs_pkg::TableDepth)
                                                          : CntW'(ec_ext);
  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign issue    = (state_q == StScan) && (scan_q < count);
  assign probe_ok = lo_q < end_q;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, end_q} - (CntW + 1)'(1);
  assign mid      = AddrW'(mid_sum >> 1);
  assign rd_addr  = (state_q == StScan) ? scan_q[AddrW-1:0] : mid;
  assign mem_re   = issue || ((state_q == StBProbe) && probe_ok);
  assign mem_we   = accept && (func_i == tlbs_pkg::FuncWrite)
                    && (32'(index_i) < tlbs_pkg::TableDepth);
  assign key_eq   = (rdata_q == key_q);
  assign key_lt   = $signed(rdata_q) < $signed(key_q);
  assign out_load = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AddrW'(index_i)] <= value_i;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && func_i == tlbs_pkg::FuncLinear) begin
          state_d = StScan;
        end else if (accept && func_i == tlbs_pkg::FuncBinary) begin
          state_d = StBProbe;
        end
      end
      StScan: begin
        if ((pend_vld_q && key_eq) || (!issue && !pend_vld_q)) begin
          state_d = StDone;
        end
      end
      StBProbe: state_d = probe_ok ? StBCmp : StDone;
      StBCmp:   state_d = key_eq ? StDone : StBProbe;
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      entry_count_q <= '0;
      scan_q        <= '0;
      lo_q          <= '0;
      end_q         <= '0;
      pend_vld_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        entry_count_q <= pwdata[EcW-1:0];
      end
      case (state_q)
        StIdle: begin
          scan_q     <= '0;
          pend_vld_q <= 1'b0;
          lo_q       <= '0;
          end_q      <= count;
        end
        StScan: begin
          pend_vld_q <= issue;
          if (issue) begin
            scan_q <= scan_q + CntW'(1);
          end
        end
        StBCmp: begin
          if (key_lt) begin
            lo_q <= CntW'(mid_q) + CntW'(1);
          end else if (!key_eq) begin
            end_q <= CntW'(mid_q);
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= value_i;
    end
    if (issue) begin
      pend_idx_q <= scan_q[AddrW-1:0];
    end
    if (state_q == StBProbe && probe_ok) begin
      mid_q <= mid;
    end
    if (state_q == StScan) begin
      res_found_q <= pend_vld_q && key_eq;
      res_pos_q   <= pend_idx_q;
    end else if (state_q == StBProbe) begin
      res_found_q <= 1'b0;
    end else if (state_q == StBCmp) begin
      res_found_q <= key_eq;
      res_pos_q   <= mid_q;
    end
    if (out_load) begin
      found_q    <= res_found_q;
      position_q <= res_found_q ? tlbs_pkg::PositionWidth'(res_pos_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = position_q;

  // APB
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[2] == tlbs_pkg::RegEntryCount);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == tlbs_pkg::RegEntryCount)
                  ? tlbs_pkg::ApbDataWidth'(entry_count_q) : '0;

endmodule

FILE: rtl/tlbs_checker.sv
module tlbs_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic [tlbs_pkg::FuncWidth-1:0]         func_i,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic                                   found_o,
  input logic [tlbs_pkg::PositionWidth-1:0]     position_o
);

  logic acc_search, acc_write;

  assign acc_search = in_valid_i && in_ready_o
                      && (func_i == tlbs_pkg::FuncLinear || func_i == tlbs_pkg::FuncBinary);
  assign acc_write  = in_valid_i && in_ready_o && (func_i == tlbs_pkg::FuncWrite);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) && $stable(position_o))
    else $error("result beat dropped or changed while stalled");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> position_o == '0)
    else $error("not-found beat with non-zero position");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_search |=> !in_ready_o)
    else $error("input ready during search");

  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_write |=> in_ready_o)
    else $error("write beat stalled input");

  a_no_result_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_search && !out_valid_o |=> !out_valid_o)
    else $error("result beat appeared one cycle after a search");

endmodule

bind table_linear_binary_search_unit tlbs_checker u_tlbs_checker (.*);
